FILE: src/abo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_pkg
// Shared types and constants for the ARGB8888 straight-alpha over blender.
// ----------------------------------------------------------------------------
package abo_pkg;

  localparam int ChanNum  = 3;   // red, green, blue
  localparam int NumW     = 17;  // channel numerator width
  localparam int DivSteps = 8;   // one quotient bit per divider stage
  localparam int DivW     = 15;  // output alpha shifted up by seven bits

  localparam logic [7:0] Full = 8'hFF;

  // Item leaving the multiply front end
  typedef struct packed {
    logic                          valid;
    logic                          copy;   // destination alpha zero
    logic                          zero;   // output alpha zero
    logic [31:0]                   pix;    // source pixel for the copy case
    logic [7:0]                    oa;
    logic [ChanNum-1:0][NumW-1:0]  num;
  } front_t;

  // Item travelling through the divider stages
  typedef struct packed {
    logic                          valid;
    logic                          copy;
    logic                          zero;
    logic [31:0]                   pix;
    logic [7:0]                    oa;
    logic [DivW-1:0]               dsh;    // divisor aligned to current bit
    logic [ChanNum-1:0][NumW-1:0]  rem;
    logic [ChanNum-1:0][7:0]       quo;
  } div_t;

endpackage

FILE: src/argb_over_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// argb_over_alpha_blend
// Straight-alpha source-over-destination compositor for ARGB8888 pixels.
// ----------------------------------------------------------------------------
// Pipeline: start passes through three multiply stages, eight one-bit divider
// stages and the output register before done rises.
// Throughput: one item per cycle; every stage is a full register, busy is
// always low and the pipeline never stalls.
// Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module argb_over_alpha_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] src_pixel,
  input  logic [31:0] dst_pixel,
  output logic        done,
  output logic [31:0] out_pixel
);

  abo_pkg::front_t                   front;
  abo_pkg::div_t [abo_pkg::DivSteps:0] dchain;
  abo_pkg::div_t                     dlast;

  assign busy = 1'b0;

  // multiply front end
  abo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .front     (front)
  );

  // seed the divider with the alpha aligned to the top quotient bit
  always_comb begin
    dchain[0].valid = front.valid;
    dchain[0].copy  = front.copy;
    dchain[0].zero  = front.zero;
    dchain[0].pix   = front.pix;
    dchain[0].oa    = front.oa;
    dchain[0].dsh   = {front.oa, 7'd0};
    dchain[0].rem   = front.num;
    dchain[0].quo   = '0;
  end

  // divider pipeline
  for (genvar i = 0; i < abo_pkg::DivSteps; i++) begin : g_div
    abo_div_stage u_div (
      .clk  (clk),
      .rst  (rst),
      .din  (dchain[i]),
      .dout (dchain[i+1])
    );
  end

  assign dlast = dchain[abo_pkg::DivSteps];

  // output register: pick copy, zero guard or blended pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dlast.valid;
    end
  end

  always_ff @(posedge clk) begin
    priority if (dlast.copy) begin
      out_pixel <= dlast.pix;
    end else if (dlast.zero) begin
      out_pixel <= 32'd0;
    end else begin
      out_pixel <= {dlast.oa, dlast.quo[2], dlast.quo[1], dlast.quo[0]};
    end
  end

endmodule

FILE: src/abo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_front
// Three-stage multiply front end: output alpha and channel numerators.
// ----------------------------------------------------------------------------
module abo_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [31:0]          src_pixel,
  input  logic [31:0]          dst_pixel,
  output abo_pkg::front_t      front
);

  // stage 1 registers
  logic                                   s1_valid;
  logic                                   s1_copy;
  logic [31:0]                            s1_pix;
  logic [7:0]                             s1_va;
  logic [15:0]                            s1_p;
  logic [abo_pkg::ChanNum-1:0][15:0]      s1_csva;
  logic [abo_pkg::ChanNum-1:0][7:0]       s1_cw;

  // stage 2 registers
  logic                                   s2_valid;
  logic                                   s2_copy;
  logic [31:0]                            s2_pix;
  logic [7:0]                             s2_oa;
  logic [abo_pkg::ChanNum-1:0][15:0]      s2_csva;
  logic [abo_pkg::ChanNum-1:0][23:0]      s2_dprod;

  logic [7:0]                             va_in;
  logic [7:0]                             wa_in;
  logic [16:0]                            p_round;
  logic [7:0]                             oa_calc;

  assign va_in   = src_pixel[31:24];
  assign wa_in   = dst_pixel[31:24];
  assign p_round = {1'b0, s1_p} + 17'd255;
  assign oa_calc = s1_va + p_round[15:8];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      front.valid <= 1'b0;
    end else begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      front.valid <= s2_valid;
    end
  end

  // stage 1: destination alpha weight and source products
  always_ff @(posedge clk) begin
    s1_copy <= (wa_in == 8'd0);
    s1_pix  <= src_pixel;
    s1_va   <= va_in;
    s1_p    <= {8'd0, wa_in} * {8'd0, (abo_pkg::Full - va_in)};
    for (int c = 0; c < abo_pkg::ChanNum; c++) begin
      s1_csva[c] <= {8'd0, src_pixel[8*c +: 8]} * {8'd0, va_in};
      s1_cw[c]   <= dst_pixel[8*c +: 8];
    end
  end

  // stage 2: output alpha and destination products
  always_ff @(posedge clk) begin
    s2_copy <= s1_copy;
    s2_pix  <= s1_pix;
    s2_oa   <= oa_calc;
    s2_csva <= s1_csva;
    for (int c = 0; c < abo_pkg::ChanNum; c++) begin
      s2_dprod[c] <= {16'd0, s1_cw[c]} * {8'd0, s1_p};
    end
  end

  // stage 3: round the destination term and add the source term
  always_ff @(posedge clk) begin
    logic [24:0] dround;
    front.copy <= s2_copy;
    front.zero <= (s2_oa == 8'd0);
    front.pix  <= s2_pix;
    front.oa   <= s2_oa;
    for (int c = 0; c < abo_pkg::ChanNum; c++) begin
      dround       = {1'b0, s2_dprod[c]} + 25'd255;
      front.num[c] <= {1'b0, s2_csva[c]} + {1'b0, dround[23:8]};
    end
  end

endmodule

FILE: src/abo_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abo_div_stage
// One restoring-division step: resolves one quotient bit on every channel.
// ----------------------------------------------------------------------------
module abo_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  abo_pkg::div_t   din,
  output abo_pkg::div_t   dout
);

  // carry the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  // compare, subtract and shift in one quotient bit per channel
  always_ff @(posedge clk) begin
    logic [abo_pkg::NumW-1:0] dext;
    dext = {{(abo_pkg::NumW-abo_pkg::DivW){1'b0}}, din.dsh};
    dout.copy <= din.copy;
    dout.zero <= din.zero;
    dout.pix  <= din.pix;
    dout.oa   <= din.oa;
    dout.dsh  <= din.dsh >> 1;
    for (int c = 0; c < abo_pkg::ChanNum; c++) begin
      if (din.rem[c] >= dext) begin
        dout.rem[c] <= din.rem[c] - dext;
        dout.quo[c] <= {din.quo[c][6:0], 1'b1};
      end else begin
        dout.rem[c] <= din.rem[c];
        dout.quo[c] <= {din.quo[c][6:0], 1'b0};
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARGB8888 straight-alpha over blender. A queue
// of pixel pairs feeds a clocked driver; each accepted pair is blended by an
// in-bench predictor, and a clocked monitor checks every done strobe against
// the oldest predicted pixel. Directed corner pairs come first, then random
// pairs with bursts of idle cycles and one full drain in the middle.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RandomItems = 400;
  localparam int QuietTail   = 50;    // last items go out back to back
  localparam int IdleLimit   = 500;   // cycles with no item or result
  localparam int TailCycles  = 20;    // settle time after the last result

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } pixel_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] src_pixel = '0;
  logic [31:0] dst_pixel = '0;
  logic        done;
  logic [31:0] out_pixel;

  pixel_pair_t   pixel_q[$];     // pairs waiting to be offered
  logic [31:0]   blended_q[$];   // predicted pixels, oldest first
  pixel_pair_t   next_pair;
  int            sent_cnt = 0;
  int            drain_at = 0;
  int            gap_left = 0;
  int            err_cnt = 0;
  int            idle_cycles = 0;
  bit            draining = 1'b0;

  argb_over_alpha_blend DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .src_pixel (src_pixel),
    .dst_pixel (dst_pixel),
    .done      (done),
    .out_pixel (out_pixel)
  );

  // Free-running 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Composite src over dst with straight alpha
  function automatic logic [31:0] blend_pixel(logic [31:0] src, logic [31:0] dst);
    int unsigned va, wa, oa, cs, cw, dst_term;
    logic [31:0] blended;
    if (dst[31:24] == 8'h00) begin
      return src;
    end
    va = src[31:24];
    wa = dst[31:24];
    oa = (va + ((wa * (abo_pkg::Full - va) + abo_pkg::Full) >> 8)) & 32'hFF;
    // guard for the divide; unreachable once dst alpha is nonzero
    if (oa == 0) begin
      return '0;
    end
    blended = '0;
    blended[31:24] = oa[7:0];
    for (int c = 0; c < 3; c++) begin
      cs = src[8*c +: 8];
      cw = dst[8*c +: 8];
      dst_term = (cw * wa * (abo_pkg::Full - va) + abo_pkg::Full) >> 8;
      blended[8*c +: 8] = ((cs * va + dst_term) / oa) & 32'hFF;
    end
    return blended;
  endfunction

  // Favor the alpha extremes, otherwise uniform
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s: out_pixel got %08h want %08h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic queue_pair(logic [31:0] src, logic [31:0] dst);
    pixel_q.push_back('{src: src, dst: dst});
  endtask

  // Stimulus, reset and end of run
  initial begin
    // destination alpha zero: source copied as is
    queue_pair(32'h0000_0000, 32'h0000_0000);
    queue_pair(32'hFFFF_FFFF, 32'h00FF_FFFF);
    queue_pair(32'h12AB_CDEF, 32'h0055_AA33);
    queue_pair(32'h00FF_FFFF, 32'h0000_0000);
    // opaque source over anything
    queue_pair(32'hFF12_3456, 32'hFF65_4321);
    queue_pair(32'hFFFF_FFFF, 32'h0100_0000);
    queue_pair(32'hFF00_0000, 32'hFFFF_FFFF);
    // transparent source over destination
    queue_pair(32'h00FF_FFFF, 32'hFF00_0000);
    queue_pair(32'h0000_0000, 32'hFFFF_FFFF);
    queue_pair(32'h00FF_FFFF, 32'h0100_0000);
    queue_pair(32'h0000_0000, 32'h01FF_FFFF);
    // smallest alphas on both sides
    queue_pair(32'h01FF_FFFF, 32'h0100_0000);
    queue_pair(32'h0100_0000, 32'h01FF_FFFF);
    // near-opaque and half blends
    queue_pair(32'hFEFF_FFFF, 32'hFF00_0000);
    queue_pair(32'hFE00_0000, 32'hFFFF_FFFF);
    queue_pair(32'h80FF_00FF, 32'h8000_FF00);
    queue_pair(32'h7F80_4020, 32'hFF10_2040);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'h0180_8080, 32'hFE7F_7F7F);
    queue_pair(32'hC0FF_FFFF, 32'h40FF_FFFF);

    drain_at = pixel_q.size() + RandomItems / 2;

    // random pairs, alphas biased toward the corners
    for (int i = 0; i < RandomItems; i++) begin
      next_pair.src = $urandom();
      next_pair.dst = $urandom();
      if ($urandom_range(0, 3) != 0) begin
        next_pair.src[31:24] = pick_alpha();
        next_pair.dst[31:24] = pick_alpha();
      end
      pixel_q.push_back(next_pair);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // wait for every pair to go in and every result to come out
    while (pixel_q.size() != 0 || start || blended_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Offer pairs, hold while busy, insert idle bursts and one full drain
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      src_pixel <= '0;
      dst_pixel <= '0;
    end else begin
      if (start && !busy) begin
        blended_q.push_back(blend_pixel(src_pixel, dst_pixel));
        sent_cnt++;
        if (sent_cnt == drain_at) begin
          draining = 1'b1;
        end
      end
      if (start && busy) begin
        // hold the offered item until it is taken
      end else if (draining && blended_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        draining = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          next_pair = pixel_q.pop_front();
          start <= 1'b1;
          src_pixel <= next_pair.src;
          dst_pixel <= next_pair.dst;
          if (pixel_q.size() > QuietTail && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 14);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each done strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (blended_q.size() == 0) begin
        report_mismatch("result with no item pending", out_pixel, 'x);
      end else if (out_pixel !== blended_q[0]) begin
        report_mismatch("pixel mismatch", out_pixel, blended_q.pop_front());
      end else begin
        void'(blended_q.pop_front());
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no item or result for %0d cycles", $time, IdleLimit);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
